### rtl/core/pcce_pkg.sv
// Package for the punch card column encoder.
// Holds transfer types, file mode and status codes and shared constants.
// No dependencies.
package pcce_pkg;

	localparam int unsigned SET_W  = 12;
	localparam int unsigned REF_W  = 20;
	localparam int unsigned CARD_W = 10;
	localparam int unsigned CHAR_W = 7;
	localparam int unsigned MODE_W = 2;
	localparam int unsigned STAT_W = 2;

	localparam logic [MODE_W-1:0] MODE_FLAT      = 2'd0;
	localparam logic [MODE_W-1:0] MODE_THOUSANDS = 2'd1;
	localparam logic [MODE_W-1:0] MODE_HUNDREDS  = 2'd2;

	localparam logic [STAT_W-1:0] STATUS_WRITTEN = 2'd0;
	localparam logic [STAT_W-1:0] STATUS_EMPTY   = 2'd1;
	localparam logic [STAT_W-1:0] STATUS_BAD_REF = 2'd2;

	localparam logic [CHAR_W-1:0] CH_STAR = 7'h2A;

	typedef struct packed {
		logic [SET_W-1:0] punch_set;
		logic [REF_W-1:0] column_ref;
	} item_t;

	typedef struct packed {
		logic [CARD_W-1:0] card_index;
		logic [REF_W-1:0]  column_in_card;
		logic [CHAR_W-1:0] column_char;
		logic              multipunch_valid;
		logic [CHAR_W-1:0] multipunch_low;
		logic [CHAR_W-1:0] multipunch_high;
		logic [STAT_W-1:0] status;
	} result_t;

	// column reference split, stage 2
	typedef struct packed {
		logic [CARD_W-1:0] card_index;
		logic [REF_W-1:0]  column_in_card;
		logic              bad_ref;
	} split_t;

	// punch set encoding, stage 2
	typedef struct packed {
		logic [CHAR_W-1:0] column_char;
		logic              multipunch_valid;
		logic [CHAR_W-1:0] multipunch_low;
		logic [CHAR_W-1:0] multipunch_high;
		logic              empty;
	} code_t;

endpackage

### rtl/core/pcce_ref_split.sv
// Column reference split into card and column by file mode.
// Reciprocal multiply in stage 1, remainder and saturation in stage 2.
// Depends on pcce_pkg.
module pcce_ref_split (
	input  logic                                clk,
	input  logic [pcce_pkg::MODE_W-1:0]         mode_s1,
	input  logic [pcce_pkg::REF_W-1:0]          column_ref_s1,
	output pcce_pkg::split_t                    split_s2
);
	import pcce_pkg::*;

	typedef enum logic [1:0] {
		DIV_NONE,
		DIV_THOU,
		DIV_HUND
	} div_sel_t;

	// exact floor(x/d) = (x*M)>>30 for all 20-bit x
	localparam int unsigned      SHIFT  = 30;
	localparam int unsigned      MAG_W  = 24;
	localparam int unsigned      PROD_W = REF_W + MAG_W;
	localparam int unsigned      QUO_W  = 14;
	localparam logic [MAG_W-1:0] MAG_THOU = 24'd1073742;
	localparam logic [MAG_W-1:0] MAG_HUND = 24'd10737419;
	localparam logic [9:0]       DIV_1000 = 10'd1000;
	localparam logic [9:0]       DIV_100  = 10'd100;
	localparam logic [QUO_W-1:0] CARD_LIM = 14'd1024;

	div_sel_t          sel_d;
	logic [MAG_W-1:0]  magic;
	logic [PROD_W-1:0] prod;

	div_sel_t          sel_s2;
	logic [QUO_W-1:0]  quo_s2;
	logic [REF_W-1:0]  ref_s2;

	logic [9:0]        divisor;
	logic [23:0]       back_prod;
	logic [QUO_W-1:0]  card_m1;

	always_comb begin
		unique case (mode_s1)
			MODE_THOUSANDS: begin
				sel_d = DIV_THOU;
				magic = MAG_THOU;
			end
			MODE_HUNDREDS: begin
				sel_d = DIV_HUND;
				magic = MAG_HUND;
			end
			default: begin
				sel_d = DIV_NONE;
				magic = MAG_HUND;
			end
		endcase
		prod = PROD_W'(column_ref_s1) * PROD_W'(magic);
	end

	always_ff @(posedge clk) begin
		sel_s2 <= sel_d;
		quo_s2 <= prod[SHIFT +: QUO_W];
		ref_s2 <= column_ref_s1;
	end

	always_comb begin
		divisor   = (sel_s2 == DIV_THOU) ? DIV_1000 : DIV_100;
		back_prod = 24'(quo_s2) * 24'(divisor);
		card_m1   = quo_s2 - 14'd1;
		unique case (sel_s2)
			DIV_THOU, DIV_HUND: begin
				split_s2.bad_ref        = (quo_s2 == '0);
				split_s2.column_in_card = ref_s2 - back_prod[REF_W-1:0];
				split_s2.card_index     = (quo_s2 > CARD_LIM) ? '1 : card_m1[CARD_W-1:0];
			end
			default: begin
				split_s2.bad_ref        = 1'b0;
				split_s2.column_in_card = ref_s2;
				split_s2.card_index     = '0;
			end
		endcase
	end

endmodule

### rtl/core/pcce_char_encode.sv
// Punch set to column character: digit, letter, symbol or multi-punch.
// Lookup in stage 1, result registered at stage 2.
// Depends on pcce_pkg.
module pcce_char_encode (
	input  logic                         clk,
	input  logic [pcce_pkg::SET_W-1:0]   punch_set_s1,
	output pcce_pkg::code_t              code_s2
);
	import pcce_pkg::*;

	localparam logic [CHAR_W-1:0] CH_0     = 7'h30;
	localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
	localparam logic [CHAR_W-1:0] CH_AMP   = 7'h26;
	localparam logic [CHAR_W-1:0] CH_SLASH = 7'h2F;
	localparam logic [CHAR_W-1:0] CH_UC_R  = 7'h52;
	localparam logic [CHAR_W-1:0] CH_UC_J  = 7'h4A;
	localparam logic [CHAR_W-1:0] CH_UC_A  = 7'h41;
	localparam logic [CHAR_W-1:0] CH_RBRC  = 7'h7D;
	localparam logic [CHAR_W-1:0] CH_LBRC  = 7'h7B;
	localparam logic [CHAR_W-1:0] CH_TILDE = 7'h7E;
	localparam logic [CHAR_W-1:0] CH_LC_R  = 7'h72;
	localparam logic [CHAR_W-1:0] CH_LC_A  = 7'h61;
	localparam logic [CHAR_W-1:0] CH_LC_J  = 7'h6A;
	localparam logic [CHAR_W-1:0] MP_BASE  = 7'h40;

	function automatic logic [3:0] low_code(input logic [SET_W-1:0] s);
		logic [3:0] r;
		r = '0;
		for (int k = SET_W; k >= 1; k--)
			if (s[k-1]) r = 4'(k);
		return r;
	endfunction

	function automatic logic [3:0] high_code(input logic [SET_W-1:0] s);
		logic [3:0] r;
		r = '0;
		for (int k = 1; k <= SET_W; k++)
			if (s[k-1]) r = 4'(k);
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] eight_two(input logic [3:0] a);
		logic [CHAR_W-1:0] r;
		r = '0;
		unique case (a)
			4'd2:    r = 7'h3A;
			4'd3:    r = 7'h23;
			4'd4:    r = 7'h40;
			4'd5:    r = 7'h27;
			4'd6:    r = 7'h3D;
			4'd7:    r = 7'h22;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] eight_three(input logic [3:0] a,
		input logic [3:0] c);
		logic [CHAR_W-1:0] r;
		r = '0;
		unique case ({a, c})
			{4'd1, 4'd12}: r = 7'h60;
			{4'd2, 4'd10}: r = 7'h5C;
			{4'd2, 4'd11}: r = 7'h21;
			{4'd2, 4'd12}: r = 7'h7C;
			{4'd3, 4'd10}: r = 7'h2C;
			{4'd3, 4'd11}: r = 7'h24;
			{4'd3, 4'd12}: r = 7'h2E;
			{4'd4, 4'd10}: r = 7'h25;
			{4'd4, 4'd12}: r = 7'h3C;
			{4'd5, 4'd10}: r = 7'h5F;
			{4'd5, 4'd11}: r = 7'h29;
			{4'd5, 4'd12}: r = 7'h28;
			{4'd6, 4'd10}: r = 7'h3E;
			{4'd6, 4'd11}: r = 7'h3B;
			{4'd6, 4'd12}: r = 7'h2B;
			default:       r = '0;
		endcase
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] pair_sym(input logic [3:0] a,
		input logic [3:0] b);
		logic [CHAR_W-1:0] r;
		logic [CHAR_W-1:0] am1;
		am1 = {3'b000, a} - 7'd1;
		r   = '0;
		priority if (b == 4'd10)
			r = (a == 4'd1) ? CH_SLASH : CH_UC_R + am1;
		else if (b == 4'd11)
			r = (a <= 4'd9) ? CH_UC_J + am1 : ((a == 4'd10) ? CH_RBRC : '0);
		else if (b == 4'd12)
			r = (a <= 4'd9) ? CH_UC_A + am1 : ((a == 4'd10) ? CH_LBRC : '0);
		else if (b == 4'd8)
			r = eight_two(a);
		else
			r = '0;
		return r;
	endfunction

	function automatic logic [CHAR_W-1:0] triple_sym(input logic [3:0] a,
		input logic [3:0] b, input logic [3:0] c);
		logic [CHAR_W-1:0] r;
		logic [CHAR_W-1:0] am1;
		am1 = {3'b000, a} - 7'd1;
		r   = '0;
		priority if (a > 4'd9)
			r = '0;
		else if (b == 4'd10 && c == 4'd11)
			r = (a == 4'd1) ? CH_TILDE : CH_LC_R + am1;
		else if (b == 4'd10 && c == 4'd12)
			r = CH_LC_A + am1;
		else if (b == 4'd11 && c == 4'd12)
			r = CH_LC_J + am1;
		else if (b == 4'd8 && a <= 4'd6)
			r = eight_three(a, c);
		else
			r = '0;
		return r;
	endfunction

	logic [3:0]        cnt;
	logic [3:0]        code_a;
	logic [3:0]        code_b;
	logic [3:0]        code_c;
	logic [SET_W-1:0]  rest;
	logic [CHAR_W-1:0] sym;
	code_t             code_d;

	always_comb begin
		cnt    = 4'($countones(punch_set_s1));
		code_a = low_code(punch_set_s1);
		code_c = high_code(punch_set_s1);
		rest   = punch_set_s1 & ~(SET_W'(1) << (code_a - 4'd1));
		code_b = low_code(rest);
		sym    = '0;
		if (cnt == 4'd2)
			sym = pair_sym(code_a, code_c);
		else if (cnt == 4'd3)
			sym = triple_sym(code_a, code_b, code_c);

		code_d                  = '0;
		code_d.empty            = (cnt == 4'd0);
		if (cnt == 4'd1) begin
			unique case (code_a)
				4'd10:   code_d.column_char = CH_0;
				4'd11:   code_d.column_char = CH_MINUS;
				4'd12:   code_d.column_char = CH_AMP;
				default: code_d.column_char = CH_0 + {3'b000, code_a};
			endcase
		end else if (cnt >= 4'd2) begin
			if (sym != '0) begin
				code_d.column_char = sym;
			end else begin
				code_d.column_char      = CH_STAR;
				code_d.multipunch_valid = 1'b1;
				code_d.multipunch_low   = MP_BASE | {1'b0, punch_set_s1[11:9],
					punch_set_s1[0], punch_set_s1[1], punch_set_s1[2]};
				code_d.multipunch_high  = MP_BASE | {1'b0, punch_set_s1[3],
					punch_set_s1[4], punch_set_s1[5], punch_set_s1[6],
					punch_set_s1[7], punch_set_s1[8]};
			end
		end
	end

	always_ff @(posedge clk) begin
		code_s2 <= code_d;
	end

endmodule

### rtl/core/punch_card_column_encoder_unit.sv
// Punch card column encoder, top level.
// The done strobe follows the start transfer through the registers valid_s1, valid_s2 and done_q.
// Throughput: one column per cycle; busy is always low, set by the 3-stage pipe
// (input register, reciprocal multiply, remainder and merge into the result register).
// Reset clears the valid pipe and sets file_mode to flat; the receiver cannot stall.
// Depends on pcce_pkg, pcce_ref_split, pcce_char_encode.
module punch_card_column_encoder_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  pcce_pkg::item_t               item,
	input  logic                          cfg_we,
	input  logic [pcce_pkg::MODE_W-1:0]   cfg_wdata,
	output logic                          done,
	output pcce_pkg::result_t             result
);
	import pcce_pkg::*;

	logic [MODE_W-1:0] file_mode_q;
	logic              valid_s1;
	logic              valid_s2;
	logic              done_q;
	item_t             item_s1;
	logic [MODE_W-1:0] mode_s1;
	split_t            split_s2;
	code_t             code_s2;
	result_t           result_d;
	result_t           result_q;

	assign busy   = 1'b0;
	assign done   = done_q;
	assign result = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			file_mode_q <= MODE_FLAT;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			if (cfg_we)
				file_mode_q <= cfg_wdata;
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			done_q   <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		item_s1 <= item;
		mode_s1 <= file_mode_q;
		if (valid_s2)
			result_q <= result_d;
	end

	pcce_ref_split u_split (
		.clk           (clk),
		.mode_s1       (mode_s1),
		.column_ref_s1 (item_s1.column_ref),
		.split_s2      (split_s2)
	);

	pcce_char_encode u_encode (
		.clk          (clk),
		.punch_set_s1 (item_s1.punch_set),
		.code_s2      (code_s2)
	);

	always_comb begin
		result_d = '0;
		priority if (split_s2.bad_ref) begin
			result_d.status = STATUS_BAD_REF;
		end else if (code_s2.empty) begin
			result_d.status = STATUS_EMPTY;
		end else begin
			result_d.status           = STATUS_WRITTEN;
			result_d.card_index       = split_s2.card_index;
			result_d.column_in_card   = split_s2.column_in_card;
			result_d.column_char      = code_s2.column_char;
			result_d.multipunch_valid = code_s2.multipunch_valid;
			result_d.multipunch_low   = code_s2.multipunch_low;
			result_d.multipunch_high  = code_s2.multipunch_high;
		end
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##3 done)
		else $error("column result missing three cycles after transfer");

	a_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.status != STATUS_WRITTEN) |->
		(result.card_index == '0 && result.column_in_card == '0 &&
		 result.column_char == '0 && !result.multipunch_valid))
		else $error("fields not cleared on flagged column");

	a_mp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.multipunch_valid) |->
		(result.multipunch_low == '0 && result.multipunch_high == '0))
		else $error("multi-punch bytes set without multi-punch");

	a_mp_star: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.multipunch_valid) |->
		(result.column_char == CH_STAR && result.multipunch_low[6] &&
		 result.multipunch_high[6]))
		else $error("multi-punch column without star or base");

endmodule

### test/tb_punch_card_column_encoder_unit.sv
// Testbench for punch_card_column_encoder_unit: directed table, then random columns per file mode.
// Every result is checked field by field against a typed expectation or a built-in column encoder.
// Depends on pcce_pkg and the RTL of the block.
module tb_punch_card_column_encoder_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import pcce_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned PHASE_COLUMNS = 195;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct {
		logic [MODE_W-1:0] mode;
		item_t             col;
		bit                typed;
		result_t           want;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	item_t               item;
	logic                cfg_we;
	logic [MODE_W-1:0]   cfg_wdata;
	logic                done;
	result_t             result;

	result_t             pending[$];
	dir_row_t            dir_rows[$];
	logic [MODE_W-1:0]   cur_mode;
	int unsigned         idle_pct;
	int unsigned         errors = 0;
	int unsigned         cycle_count = 0;

	punch_card_column_encoder_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.result    (result)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic result_t encode_column(input item_t it, input logic [MODE_W-1:0] mode);
		result_t           r;
		logic [STAT_W-1:0] st;
		int unsigned       divisor, quot, n;
		logic [7:0]        code[3];
		logic [7:0]        a, b, c, ch;
		logic [6:0]        lo, hi;
		r = '0;
		r.column_in_card = it.column_ref;
		divisor = (mode == MODE_THOUSANDS) ? 1000 : (mode == MODE_HUNDREDS) ? 100 : 0;
		if (divisor != 0) begin
			if (it.column_ref < divisor) begin
				r.status = STATUS_BAD_REF;
			end else begin
				quot = it.column_ref / divisor - 1;
				r.card_index = (quot > 1023) ? 10'h3FF : quot[CARD_W-1:0];
				r.column_in_card = REF_W'(it.column_ref % divisor);
			end
		end
		n = 0;
		code[0] = 8'd0;
		code[1] = 8'd0;
		code[2] = 8'd0;
		for (int k = 1; k <= 12; k++) begin
			if (it.punch_set[k-1]) begin
				if (n < 3) code[n] = 8'(k);
				n++;
			end
		end
		if (r.status == STATUS_WRITTEN && n == 0) r.status = STATUS_EMPTY;
		if (r.status != STATUS_WRITTEN) begin
			st = r.status;
			r = '0;
			r.status = st;
			return r;
		end
		a = code[0];
		b = code[1];
		c = code[2];
		ch = 8'd0;
		if (n == 1) begin
			unique case (a)
				8'd10: ch = "0";
				8'd11: ch = "-";
				8'd12: ch = "&";
				default: ch = "0" + a;
			endcase
		end else if (n == 2) begin
			unique case (b)
				8'd10: ch = (a == 8'd1) ? "/" : "R" + a - 8'd1;
				8'd11: ch = (a <= 8'd9) ? "J" + a - 8'd1 : (a == 8'd10) ? "}" : 8'd0;
				8'd12: ch = (a <= 8'd9) ? "A" + a - 8'd1 : (a == 8'd10) ? "{" : 8'd0;
				8'd8: begin
					unique case (a)
						8'd2: ch = ":";
						8'd3: ch = "#";
						8'd4: ch = "@";
						8'd5: ch = "'";
						8'd6: ch = "=";
						8'd7: ch = "\"";
						default: ch = 8'd0;
					endcase
				end
				default: ch = 8'd0;
			endcase
		end else if (n == 3 && a <= 8'd9) begin
			if (b == 8'd10 && c == 8'd11) begin
				ch = (a == 8'd1) ? "~" : "r" + a - 8'd1;
			end else if (b == 8'd10 && c == 8'd12) begin
				ch = "a" + a - 8'd1;
			end else if (b == 8'd11 && c == 8'd12) begin
				ch = "j" + a - 8'd1;
			end else if (b == 8'd8 && c >= 8'd10) begin
				unique case (a)
					8'd1: ch = (c == 8'd12) ? 8'h60 : 8'd0;  // backquote
					8'd2: ch = (c == 8'd10) ? "\\" : (c == 8'd11) ? "!" : "|";
					8'd3: ch = (c == 8'd10) ? "," : (c == 8'd11) ? "$" : ".";
					8'd4: ch = (c == 8'd10) ? "%" : (c == 8'd11) ? 8'd0 : "<";
					8'd5: ch = (c == 8'd10) ? "_" : (c == 8'd11) ? ")" : "(";
					8'd6: ch = (c == 8'd10) ? ">" : (c == 8'd11) ? ";" : "+";
					default: ch = 8'd0;
				endcase
			end
		end
		r.column_char = ch[CHAR_W-1:0];
		if (ch == 8'd0) begin
			lo = 7'd64;
			hi = 7'd64;
			for (int k = 1; k <= 12; k++) begin
				if (it.punch_set[k-1]) begin
					if (k <= 3) lo[3-k] = 1'b1;
					else if (k >= 10) lo[k-7] = 1'b1;
					else hi[9-k] = 1'b1;
				end
			end
			r.column_char = CH_STAR;
			r.multipunch_valid = 1'b1;
			r.multipunch_low = lo;
			r.multipunch_high = hi;
		end
		return r;
	endfunction

	function automatic item_t rand_column(input logic [MODE_W-1:0] mode);
		item_t       it;
		int unsigned pick, want_n, divisor;
		pick = $urandom_range(99);
		if (pick < 10) begin
			it.punch_set = '0;
		end else if (pick < 30) begin
			it.punch_set = SET_W'($urandom);
		end else begin
			want_n = (pick < 50) ? 1 : (pick < 75) ? 2 : 3;
			it.punch_set = '0;
			while ($countones(it.punch_set) < want_n)
				it.punch_set[$urandom_range(SET_W - 1)] = 1'b1;
		end
		divisor = (mode == MODE_HUNDREDS) ? 100 : 1000;
		pick = $urandom_range(99);
		if (pick < 15)
			it.column_ref = REF_W'($urandom_range(divisor - 1));
		else if (pick < 30)
			it.column_ref = REF_W'($urandom_range(20'hFFFFF / divisor, 1) * divisor);
		else if (pick < 40)
			it.column_ref = 20'hFFFFF - REF_W'($urandom_range(15));
		else
			it.column_ref = REF_W'($urandom);
		return it;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		if (errors < 50)
			$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	task automatic add_row(input logic [MODE_W-1:0] mode, input logic [SET_W-1:0] set,
			input logic [REF_W-1:0] cref, input bit typed, input result_t want);
		dir_row_t row;
		row.mode = mode;
		row.col.punch_set = set;
		row.col.column_ref = cref;
		row.typed = typed;
		row.want = want;
		dir_rows = {dir_rows, row};
	endtask

	task automatic send_column(input item_t it, input result_t want);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			item <= rand_column(cur_mode);
			@(negedge clk);
		end
		start <= 1'b1;
		item <= it;
		do @(posedge clk); while (busy);
		pending = {pending, want};
	endtask

	task automatic wait_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending.size() != 0) @(posedge clk);
	endtask

	task automatic load_mode(input logic [MODE_W-1:0] m);
		wait_drained();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= m;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_mode = m;
	endtask

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n) begin
			if ($isunknown(done)) begin
				report_mismatch("done unknown", 0, 0);
			end else if (done) begin
				if (pending.size() == 0) begin
					report_mismatch("result with no transfer pending", result.column_char, 0);
				end else begin
					want = pending.pop_front();
					if (result.card_index !== want.card_index)
						report_mismatch("card_index", result.card_index, want.card_index);
					if (result.column_in_card !== want.column_in_card)
						report_mismatch("column_in_card", result.column_in_card,
							want.column_in_card);
					if (result.column_char !== want.column_char)
						report_mismatch("column_char", result.column_char, want.column_char);
					if (result.multipunch_valid !== want.multipunch_valid)
						report_mismatch("multipunch_valid", result.multipunch_valid,
							want.multipunch_valid);
					if (result.multipunch_low !== want.multipunch_low)
						report_mismatch("multipunch_low", result.multipunch_low,
							want.multipunch_low);
					if (result.multipunch_high !== want.multipunch_high)
						report_mismatch("multipunch_high", result.multipunch_high,
							want.multipunch_high);
					if (result.status !== want.status)
						report_mismatch("status", result.status, want.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_punch_card_column_encoder_unit failed");
			$finish;
		end
	end

	initial begin : stimulus
		logic [MODE_W-1:0] phase_mode[9];
		item_t             it;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = MODE_FLAT;
		cur_mode = MODE_FLAT;
		idle_pct = 0;
		phase_mode = '{MODE_THOUSANDS, MODE_HUNDREDS, MODE_FLAT, 2'd3, MODE_HUNDREDS,
			MODE_THOUSANDS, MODE_FLAT, MODE_HUNDREDS, MODE_THOUSANDS};

		// flat mode straight after reset
		add_row(MODE_FLAT, 12'h000, 20'h00000, 1'b1, '{0, 0, 0, 0, 0, 0, STATUS_EMPTY});
		add_row(MODE_FLAT, 12'h001, 20'hFFFFF, 1'b1,
			'{0, 20'hFFFFF, 7'("1"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_FLAT, 12'h200, 20'd5, 1'b1, '{0, 5, 7'("0"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_FLAT, 12'h400, 20'd6, 1'b1, '{0, 6, 7'("-"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_FLAT, 12'h800, 20'd7, 1'b1, '{0, 7, 7'("&"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_FLAT, 12'hFFF, 20'd12, 1'b1,
			'{0, 12, CH_STAR, 1, 7'h7F, 7'h7F, STATUS_WRITTEN});
		// pairs and triples, in and out of the symbol table
		add_row(MODE_FLAT, 12'h201, 20'd1, 1'b0, '0);
		add_row(MODE_FLAT, 12'h600, 20'd2, 1'b0, '0);
		add_row(MODE_FLAT, 12'hC00, 20'd3, 1'b0, '0);
		add_row(MODE_FLAT, 12'h082, 20'd4, 1'b0, '0);
		add_row(MODE_FLAT, 12'h081, 20'd5, 1'b0, '0);
		add_row(MODE_FLAT, 12'h601, 20'd6, 1'b0, '0);
		add_row(MODE_FLAT, 12'hA04, 20'd7, 1'b0, '0);
		add_row(MODE_FLAT, 12'hD00, 20'd8, 1'b0, '0);
		add_row(MODE_FLAT, 12'h488, 20'd9, 1'b0, '0);
		add_row(MODE_FLAT, 12'h282, 20'd10, 1'b0, '0);
		// bad reference wins over empty set; card number saturation
		add_row(MODE_THOUSANDS, 12'h000, 20'd999, 1'b1, '{0, 0, 0, 0, 0, 0, STATUS_BAD_REF});
		add_row(MODE_THOUSANDS, 12'h001, 20'd1000, 1'b1,
			'{0, 0, 7'("1"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_THOUSANDS, 12'h100, 20'hFFFFF, 1'b1,
			'{10'h3FF, 575, 7'("9"), 0, 0, 0, STATUS_WRITTEN});
		add_row(MODE_HUNDREDS, 12'hFFF, 20'd99, 1'b1, '{0, 0, 0, 0, 0, 0, STATUS_BAD_REF});
		add_row(MODE_HUNDREDS, 12'h000, 20'd100, 1'b1, '{0, 0, 0, 0, 0, 0, STATUS_EMPTY});
		add_row(MODE_HUNDREDS, 12'h004, 20'hFFFFF, 1'b1,
			'{10'h3FF, 75, 7'("3"), 0, 0, 0, STATUS_WRITTEN});
		// unused mode acts as flat
		add_row(2'd3, 12'h010, 20'hFFFFF, 1'b1,
			'{0, 20'hFFFFF, 7'("5"), 0, 0, 0, STATUS_WRITTEN});
		add_row(2'd3, 12'h000, 20'd0, 1'b1, '{0, 0, 0, 0, 0, 0, STATUS_EMPTY});

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].mode != cur_mode) load_mode(dir_rows[i].mode);
			send_column(dir_rows[i].col, dir_rows[i].typed ? dir_rows[i].want :
				encode_column(dir_rows[i].col, cur_mode));
		end

		foreach (phase_mode[p]) begin
			load_mode(phase_mode[p]);
			idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 57 : 21;
			repeat (PHASE_COLUMNS) begin
				it = rand_column(cur_mode);
				send_column(it, encode_column(it, cur_mode));
			end
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("tb_punch_card_column_encoder_unit passed");
		else
			$display("tb_punch_card_column_encoder_unit failed");
		$finish;
	end

endmodule
